[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define AST_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rasterizer check failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rasterizer check failed");

`endif

[rtl/core/eftr_pkg.sv]
`default_nettype none

package eftr_pkg;

  // Default screen geometry and vertex fixed point format.
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;
  localparam int FRACTION_BITS_DEF = 4;

  // Field widths of the request and result channels.
  localparam int ACTION_W = 2;
  localparam int COORD_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int RD_COL_W = 9;
  localparam int RD_ROW_W = 8;

  // Request kinds. The fourth code is unused and answers with an empty result.
  typedef enum logic [ACTION_W-1:0] {
    ACT_FILL  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

endpackage

`default_nettype wire

[rtl/core/eftr_ram.sv]
`default_nettype none

module eftr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/edge_function_triangle_rasterizer.sv]
// Triangle rasterizer that owns an RGB332 frame store of SCREEN_WIDTH x SCREEN_HEIGHT pixels.
// Requests arrive on in_valid/in_ready with an action code: fill a triangle given by three
// signed fixed point vertices and a color, clear the whole frame, or read one pixel.
// Every request returns exactly one result on out_valid/out_ready; only a read carries a
// pixel value, all other results are zero with out_is_read_result low.
// Steps, from the accepting edge to the loading of the result register:
//   read          frame store read on acceptance, ST_READ takes the word, ST_DONE loads it
//   fill          ST_BOX, ST_DIFF, ST_MUL, ST_INIT, then ST_SCAN over the clipped bounding
//                 box and ST_DONE; an empty box goes from ST_BOX straight to ST_DONE
//   clear         ST_CLEAR sweeps the frame store, one word per cycle, then ST_DONE
//   unused code   straight to ST_DONE
// The block works on one request at a time and takes the next one in the cycle after the
// result register is loaded; the scan steps through the box one pixel per cycle and
// writes the covered pixels through the single write port.
// After reset the block sweeps every frame store word to zero with in_ready low. A stalled
// receiver holds the result in the output register; one more request may then be taken
// and worked on, and its result waits until the register frees.
`default_nettype none

module edge_function_triangle_rasterizer #(
  parameter int SCREEN_WIDTH  = eftr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = eftr_pkg::SCREEN_HEIGHT_DEF,
  parameter int FRACTION_BITS = eftr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [eftr_pkg::ACTION_W-1:0]       in_action,
  input  logic signed [eftr_pkg::COORD_W-1:0] in_vertex0_x,
  input  logic signed [eftr_pkg::COORD_W-1:0] in_vertex0_y,
  input  logic signed [eftr_pkg::COORD_W-1:0] in_vertex1_x,
  input  logic signed [eftr_pkg::COORD_W-1:0] in_vertex1_y,
  input  logic signed [eftr_pkg::COORD_W-1:0] in_vertex2_x,
  input  logic signed [eftr_pkg::COORD_W-1:0] in_vertex2_y,
  input  logic [eftr_pkg::COLOR_W-1:0]        in_fill_color,
  input  logic [eftr_pkg::RD_COL_W-1:0]       in_read_column,
  input  logic [eftr_pkg::RD_ROW_W-1:0]       in_read_row,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [eftr_pkg::COLOR_W-1:0]        out_pixel_value,
  output logic                                out_is_read_result
);

  import eftr_pkg::*;

  localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 1);
  localparam int DIM_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int BOX_W  = ((COORD_W > DIM_W) ? COORD_W : DIM_W) + 2;
  localparam int PX_W   = DIM_W + FRACTION_BITS + 1;
  localparam int DIFF_W = ((PX_W > COORD_W) ? PX_W : COORD_W) + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int E_W    = PROD_W + 1;
  localparam int BIAS   = (1 << FRACTION_BITS) - 1;

  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BOX,
    ST_DIFF,
    ST_MUL,
    ST_INIT,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_t;

  // Control registers.
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] addr_row_r, addr_row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              clr_item_r, clr_item_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_pixel_r;
  logic              out_read_r;

  // Request payload and setup results.
  logic signed [COORD_W-1:0] vx_r [3];
  logic signed [COORD_W-1:0] vy_r [3];
  logic [COLOR_W-1:0]        color_r;
  logic                      rd_ok_r;
  logic [COLOR_W-1:0]        res_value_r;
  logic                      res_read_r;
  logic [COL_W-1:0]          x0_r, x_last_r;
  logic [ROW_W-1:0]          y0_r, y_last_r;
  logic signed [DIFF_W-1:0]  dax_r [3];
  logic signed [DIFF_W-1:0]  dby_r [3];
  logic signed [DIFF_W-1:0]  day_r [3];
  logic signed [DIFF_W-1:0]  dbx_r [3];
  logic signed [PROD_W-1:0]  pa_r [3];
  logic signed [PROD_W-1:0]  pb_r [3];
  logic signed [E_W-1:0]     sx_r [3];
  logic signed [E_W-1:0]     sy_r [3];
  logic signed [E_W-1:0]     e_r [3];
  logic signed [E_W-1:0]     e_row_r [3];

  // Combinational helpers.
  logic                      accept, rd_in_range, covered, col_last, row_last;
  logic                      out_free, out_load, box_empty;
  logic [ADDR_W-1:0]         rd_addr, base_addr;
  logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic signed [BOX_W-1:0]   tx0, tx1, ty0, ty1, cx0, cx1, cy0, cy1, cx_last, cy_last;
  logic signed [PX_W-1:0]    px0, py0;
  logic signed [COORD_W-1:0] ea_x [3];
  logic signed [COORD_W-1:0] ea_y [3];
  logic signed [COORD_W-1:0] eb_x [3];
  logic signed [COORD_W-1:0] eb_y [3];
  logic                      ram_we, ram_re;
  logic [COLOR_W-1:0]        ram_wdata, ram_rdata;

  // Truncation toward zero of a fixed point coordinate to whole pixels.
  function automatic logic signed [BOX_W-1:0] trunc_fx(input logic signed [COORD_W-1:0] v);
    logic signed [BOX_W-1:0] w;
    w = BOX_W'(v);
    if (v < 0) begin
      w = w + BOX_W'(BIAS);
    end
    return w >>> FRACTION_BITS;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == ST_DONE) && out_free;

  // Read address and the on-screen test of a read request.
  assign rd_in_range = (int'(in_read_column) < SCREEN_WIDTH) &&
                       (int'(in_read_row) < SCREEN_HEIGHT);
  assign rd_addr     = ADDR_W'(in_read_row) * ROW_STRIDE + ADDR_W'(in_read_column);

  // Bounding box of the stored vertices, truncated and clipped to the screen.
  always_comb begin
    min_x = (vx_r[0] < vx_r[1]) ? vx_r[0] : vx_r[1];
    min_x = (min_x < vx_r[2]) ? min_x : vx_r[2];
    max_x = (vx_r[0] > vx_r[1]) ? vx_r[0] : vx_r[1];
    max_x = (max_x > vx_r[2]) ? max_x : vx_r[2];
    min_y = (vy_r[0] < vy_r[1]) ? vy_r[0] : vy_r[1];
    min_y = (min_y < vy_r[2]) ? min_y : vy_r[2];
    max_y = (vy_r[0] > vy_r[1]) ? vy_r[0] : vy_r[1];
    max_y = (max_y > vy_r[2]) ? max_y : vy_r[2];
    tx0 = trunc_fx(min_x);
    tx1 = trunc_fx(max_x);
    ty0 = trunc_fx(min_y);
    ty1 = trunc_fx(max_y);
    cx0 = (tx0 < 0) ? '0 : tx0;
    cy0 = (ty0 < 0) ? '0 : ty0;
    cx1 = (tx1 > BOX_W'(SCREEN_WIDTH)) ? BOX_W'(SCREEN_WIDTH) : tx1;
    cy1 = (ty1 > BOX_W'(SCREEN_HEIGHT)) ? BOX_W'(SCREEN_HEIGHT) : ty1;
    cx_last = cx1 - BOX_W'(1);
    cy_last = cy1 - BOX_W'(1);
    box_empty = (cx1 <= cx0) || (cy1 <= cy0);
  end

  // Edge endpoints: edge 0 runs v0 to v1, edge 1 v1 to v2, edge 2 v2 to v0.
  always_comb begin
    ea_x[0] = vx_r[0];
    ea_y[0] = vy_r[0];
    eb_x[0] = vx_r[1];
    eb_y[0] = vy_r[1];
    ea_x[1] = vx_r[1];
    ea_y[1] = vy_r[1];
    eb_x[1] = vx_r[2];
    eb_y[1] = vy_r[2];
    ea_x[2] = vx_r[2];
    ea_y[2] = vy_r[2];
    eb_x[2] = vx_r[0];
    eb_y[2] = vy_r[0];
  end

  // Corner of the box in fixed point and its frame store address.
  assign px0       = PX_W'(x0_r) << FRACTION_BITS;
  assign py0       = PX_W'(y0_r) << FRACTION_BITS;
  assign base_addr = ADDR_W'(y0_r) * ROW_STRIDE + ADDR_W'(x0_r);

  // Inside test: the pixel lies on the same side of every edge, or on an edge.
  assign covered = ((e_r[0] >= 0) && (e_r[1] >= 0) && (e_r[2] >= 0)) ||
                   ((e_r[0] <= 0) && (e_r[1] <= 0) && (e_r[2] <= 0));
  assign col_last = (col_r == x_last_r);
  assign row_last = (row_r == y_last_r);

  // Frame store port use: sweep writes zero, scan writes the fill color.
  assign ram_we    = (state_r == ST_CLEAR) || ((state_r == ST_SCAN) && covered);
  assign ram_wdata = (state_r == ST_SCAN) ? color_r : '0;
  assign ram_re    = accept && (in_action == ACT_READ) && rd_in_range;

  eftr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Sequencer: clearing sweep, fill setup and scan, read and result hand-off.
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    addr_row_nxt  = addr_row_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    clr_item_nxt  = clr_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      ST_CLEAR: begin
        if (addr_r == LAST_ADDR) begin
          addr_nxt     = '0;
          clr_item_nxt = 1'b0;
          state_nxt    = clr_item_r ? ST_DONE : ST_IDLE;
        end else begin
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (action_t'(in_action))
            ACT_FILL:  state_nxt = ST_BOX;
            ACT_CLEAR: begin
              addr_nxt     = '0;
              clr_item_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            ACT_READ:  state_nxt = ST_READ;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_BOX: begin
        state_nxt = box_empty ? ST_DONE : ST_DIFF;
      end
      ST_DIFF: begin
        addr_row_nxt = base_addr;
        addr_nxt     = base_addr;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        col_nxt   = x0_r;
        row_nxt   = y0_r;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (col_last) begin
          if (row_last) begin
            col_nxt   = '0;
            row_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            col_nxt      = x0_r;
            row_nxt      = row_r + ROW_W'(1);
            addr_row_nxt = addr_row_r + ROW_STRIDE;
            addr_nxt     = addr_row_r + ROW_STRIDE;
          end
        end else begin
          col_nxt  = col_r + COL_W'(1);
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, scan counters and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      addr_row_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      addr_row_r  <= addr_row_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      clr_item_r  <= clr_item_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_pixel_r <= res_value_r;
      out_read_r  <= res_read_r;
    end
  end

  // Request capture, fill setup pipeline and incremental edge stepping.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          vx_r[0]     <= in_vertex0_x;
          vy_r[0]     <= in_vertex0_y;
          vx_r[1]     <= in_vertex1_x;
          vy_r[1]     <= in_vertex1_y;
          vx_r[2]     <= in_vertex2_x;
          vy_r[2]     <= in_vertex2_y;
          color_r     <= in_fill_color;
          rd_ok_r     <= rd_in_range;
          res_value_r <= '0;
          res_read_r  <= 1'b0;
        end
      end
      ST_BOX: begin
        x0_r     <= cx0[COL_W-1:0];
        x_last_r <= cx_last[COL_W-1:0];
        y0_r     <= cy0[ROW_W-1:0];
        y_last_r <= cy_last[ROW_W-1:0];
      end
      ST_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          dax_r[k] <= DIFF_W'(ea_x[k]) - DIFF_W'(px0);
          dby_r[k] <= DIFF_W'(eb_y[k]) - DIFF_W'(py0);
          day_r[k] <= DIFF_W'(ea_y[k]) - DIFF_W'(py0);
          dbx_r[k] <= DIFF_W'(eb_x[k]) - DIFF_W'(px0);
          sx_r[k]  <= (E_W'(ea_y[k]) - E_W'(eb_y[k])) <<< FRACTION_BITS;
          sy_r[k]  <= (E_W'(eb_x[k]) - E_W'(ea_x[k])) <<< FRACTION_BITS;
        end
      end
      ST_MUL: begin
        for (int k = 0; k < 3; k++) begin
          pa_r[k] <= dax_r[k] * dby_r[k];
          pb_r[k] <= day_r[k] * dbx_r[k];
        end
      end
      ST_INIT: begin
        for (int k = 0; k < 3; k++) begin
          e_r[k]     <= E_W'(pa_r[k]) - E_W'(pb_r[k]);
          e_row_r[k] <= E_W'(pa_r[k]) - E_W'(pb_r[k]);
        end
      end
      ST_SCAN: begin
        for (int k = 0; k < 3; k++) begin
          if (col_last) begin
            if (!row_last) begin
              e_row_r[k] <= e_row_r[k] + sy_r[k];
              e_r[k]     <= e_row_r[k] + sy_r[k];
            end
          end else begin
            e_r[k] <= e_r[k] + sx_r[k];
          end
        end
      end
      ST_READ: begin
        res_value_r <= rd_ok_r ? ram_rdata : '0;
        res_read_r  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_value    = out_pixel_r;
  assign out_is_read_result = out_read_r;

endmodule

`default_nettype wire

[rtl/core/eftr_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module eftr_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [eftr_pkg::COLOR_W-1:0] out_pixel_value,
  input wire logic                         out_is_read_result
);

  import eftr_pkg::*;

  // A stalled result stays put with its payload.
  `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_value) && $stable(out_is_read_result))

  // One request at a time: ready drops right after a request is taken.
  `AST_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // Only a read answer may carry a pixel value.
  `AST_SAME(a_zero_non_read, out_valid && !out_is_read_result, out_pixel_value == COLOR_W'(0))

  // The frame store sweep after reset keeps requests out.
  `AST_SAME(a_sweep_after_reset, $rose(rst_n), !in_ready)

endmodule

bind edge_function_triangle_rasterizer eftr_checker u_eftr_checker (.*);

`default_nettype wire
